### src/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and the arctangent table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  // CORDIC vector width: the Q.28 arguments grow by the CORDIC gain.
  localparam int CW = 38;
  // Angle accumulator width, Q.30 radians.
  localparam int ZW = 34;
  // Square root: one result bit per stage, radicand up to 2^56.
  localparam int SQ_STAGES = 29;
  localparam int RW = 58;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  typedef struct packed {
    logic signed [33:0] ax_num;
    logic signed [33:0] ax_den;
    logic signed [33:0] az_num;
    logic signed [33:0] az_den;
    logic signed [29:0] s;
  } args_t;

  // atan(2^-i) in Q.30, truncated.
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'h3243F6A8;
      1: a = 32'h1DAC6705;
      2: a = 32'h0FADBAFC;
      3: a = 32'h07F56EA6;
      4: a = 32'h03FEAB76;
      5: a = 32'h01FFD55B;
      6: a = 32'h00FFFAAA;
      7: a = 32'h007FFF55;
      8: a = 32'h003FFFEA;
      9: a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      24: a = 32'h0000003F;
      25: a = 32'h0000001F;
      26: a = 32'h0000000F;
      27: a = 32'h00000007;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

### src/quaternion_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Unit quaternion (Q1.14) to x-y-z Euler angles (Q2.13 radians; angle_y Q1.13).
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) takes one quaternion item
//   (quat_w/x/y/z) per cycle while in_ready_o is high. The output channel
//   (out_valid_o/out_ready_i) delivers angle_x, angle_y and angle_z for
//   each item, in order. Registers hold the products, the sums and the
//   clamped arcsine argument, and its square; then come the bit-serial
//   square root pipeline, the CORDIC pipeline and the rounding register.
//   The sums wait in a delay line beside the square root. Throughput is
//   one item per cycle while the output is not stalled.
//   The whole pipeline advances together; when the receiver holds off with
//   out_ready_i low while a result is waiting, every stage holds and
//   in_ready_o drops, so no item is lost or repeated. Bubbles are not
//   squeezed out; in_ready_o stays high whenever the output register is
//   free or being read.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] angle_x_o,
  output logic signed [14:0] angle_y_o,
  output logic signed [15:0] angle_z_o
);
  import qte_pkg::*;

  localparam int SQ_LAT = SQ_STAGES + 1;
  localparam int DEPTH  = 3 + SQ_LAT + CORDIC_STAGES + 1 + 1;

  logic en;
  logic [DEPTH-1:0] vld_q;

  assign en = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Products.
  logic signed [31:0] yz_q, wx_q, xx_q, yy_q, xy_q, wz_q, zz_q, xz_q, wy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      yz_q <= quat_y_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      zz_q <= quat_z_i * quat_z_i;
      xz_q <= quat_x_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
    end
  end

  // Sums in Q.28 and the clamped arcsine argument.
  args_t args_d, args_q;
  logic signed [33:0] s_raw;
  always_comb begin
    args_d.ax_num = (34'(yz_q) + 34'(wx_q)) <<< 1;
    args_d.ax_den = ONE_Q28 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    args_d.az_num = (34'(xy_q) + 34'(wz_q)) <<< 1;
    args_d.az_den = ONE_Q28 - ((34'(yy_q) + 34'(zz_q)) <<< 1);
    s_raw = (34'(xz_q) - 34'(wy_q)) <<< 1;
    if (s_raw > ONE_Q28) begin
      args_d.s = 30'(ONE_Q28);
    end else if (s_raw < -ONE_Q28) begin
      args_d.s = 30'(-ONE_Q28);
    end else begin
      args_d.s = 30'(s_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      args_q <= args_d;
    end
  end

  // Square of the arcsine argument.
  logic [28:0] s_abs;
  logic [56:0] sq_q;
  args_t dly_q [SQ_LAT+1];
  assign s_abs = args_q.s[29] ? 29'(-args_q.s) : 29'(args_q.s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q     <= 57'(s_abs) * 57'(s_abs);
      dly_q[0] <= args_q;
    end
  end

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly_q[k+1] <= dly_q[k];
      end
    end
  end

  logic [28:0] root;
  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (sq_q),
    .root_o (root)
  );

  // dly_q[SQ_LAT] lines up with the square root result.
  args_t arg_c;
  zval_t zx, zy, zz;
  assign arg_c = dly_q[SQ_LAT];

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (cval_t'(arg_c.ax_den)),
    .y_i   (cval_t'(arg_c.ax_num)),
    .z_o   (zx)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (cval_t'({1'b0, root})),
    .y_i   (cval_t'(arg_c.s)),
    .z_o   (zy)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (cval_t'(arg_c.az_den)),
    .y_i   (cval_t'(arg_c.az_num)),
    .z_o   (zz)
  );

  // Q.30 to Q.13 with round half up, then saturation.
  function automatic logic signed [17:0] round_sat(input logic signed [35:0] v,
                                                   input logic signed [17:0] lim);
    logic signed [35:0] t;
    logic signed [17:0] r;
    t = v + 36'sd65536;
    r = 18'(t >>> 17);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [17:0] ax_r, ay_r, az_r;
  assign ax_r = round_sat(36'(zx), PI_Q13);
  assign ay_r = round_sat(-36'(zy), HALF_PI_Q13);
  assign az_r = round_sat(36'(zz), PI_Q13);

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_x_o <= ax_r[15:0];
      angle_y_o <= ay_r[14:0];
      angle_z_o <= az_r[15:0];
    end
  end

endmodule

### src/qte_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root of 2^56 - sq, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [56:0] sq_i,
  output logic [28:0] root_o
);
  import qte_pkg::*;

  logic [RW-1:0] rem_q  [SQ_STAGES+1];
  logic [RW-1:0] root_q [SQ_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= (RW'(1) << 56) - RW'(sq_i);
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam int BITPOS = 2 * (SQ_STAGES - 1 - k);
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d, root_d;

    always_comb begin
      trial = root_q[k] + (RW'(1) << BITPOS);
      if (rem_q[k] >= trial) begin
        rem_d  = rem_q[k] - trial;
        root_d = (root_q[k] >> 1) + (RW'(1) << BITPOS);
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
      end
    end
  end

  assign root_o = root_q[SQ_STAGES][28:0];

endmodule

### src/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in Q.30 radians.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  qte_pkg::cval_t       x_i,
  input  qte_pkg::cval_t       y_i,
  output qte_pkg::zval_t       z_o
);
  import qte_pkg::*;

  cval_t x_q [STAGES+1];
  cval_t y_q [STAGES+1];
  zval_t z_q [STAGES+1];
  logic  zero_q [STAGES+1];

  // A vector in the left half plane is first turned by a quarter turn.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= HALF_PI_Q30;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -HALF_PI_Q30;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam zval_t ATAN = zval_t'(atan_q30(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end
      end
    end
  end

  // atan2(0, 0) is defined as zero.
  assign z_o = zero_q[STAGES] ? '0 : z_q[STAGES];

endmodule

### src/qte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks of the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] angle_x_o,
  input logic signed [14:0] angle_y_o,
  input logic signed [15:0] angle_z_o
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_x_o)
      && $stable(angle_y_o) && $stable(angle_z_o))
    else $error("result changed while stalled");

  // Input is only blocked by a result that is not taken.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_x_o <= 16'sd25736 && angle_x_o >= -16'sd25736)
    else $error("angle_x out of range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_y_o <= 15'sd12868 && angle_y_o >= -15'sd12868)
    else $error("angle_y out of range");

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_z_o <= 16'sd25736 && angle_z_o >= -16'sd25736)
    else $error("angle_z out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .angle_x_o   (angle_x_o),
  .angle_y_o   (angle_y_o),
  .angle_z_o   (angle_z_o)
);
